[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

[sv/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// u8d_pkg
// Types, constants and lookup functions for the UTF-8 decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 32;
  localparam int CNT_W  = 3;

  typedef struct packed {
    logic              emit;
    logic [CP_W-1:0]   code_point;
    logic              overlength;
    logic [CP_W-1:0]   acc_next;
    logic [CNT_W-1:0]  bytes_left_next;
    logic [CNT_W-1:0]  seq_len_next;
  } step_res_t;

  function automatic logic [CNT_W-1:0] lead_ones(input logic [BYTE_W-1:0] b);
    logic [CNT_W-1:0] n;
    casez (b)
      8'b0???????: n = 3'd0;
      8'b10??????: n = 3'd1;
      8'b110?????: n = 3'd2;
      8'b1110????: n = 3'd3;
      8'b11110???: n = 3'd4;
      8'b111110??: n = 3'd5;
      default:     n = 3'd6;
    endcase
    return n;
  endfunction

  function automatic logic [CP_W-1:0] min_for_length(input logic [CNT_W-1:0] len);
    logic [CP_W-1:0] m;
    case (len)
      3'd2:    m = 32'h0000_0080;
      3'd3:    m = 32'h0000_0800;
      3'd4:    m = 32'h0001_0000;
      3'd5:    m = 32'h0011_0000;
      3'd6:    m = 32'h0400_0000;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

[sv/u8d_step.sv]
// ----------------------------------------------------------------------------
// u8d_step
// Next-state and result logic for one byte of the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8d_step (
  input  logic [u8d_pkg::BYTE_W-1:0] byte_in,
  input  logic                       end_of_stream,
  input  logic [u8d_pkg::CP_W-1:0]   acc,
  input  logic [u8d_pkg::CNT_W-1:0]  bytes_left,
  input  logic [u8d_pkg::CNT_W-1:0]  seq_len,
  output u8d_pkg::step_res_t         res
);

  logic [u8d_pkg::CNT_W-1:0]  ones;
  logic [u8d_pkg::BYTE_W-1:0] lead_mask;
  logic [u8d_pkg::CP_W-1:0]   acc_shift;
  logic [u8d_pkg::CNT_W-1:0]  bl_dec;

  assign ones      = u8d_pkg::lead_ones(byte_in);
  assign lead_mask = 8'hff >> ones;
  assign acc_shift = {acc[u8d_pkg::CP_W-7:0], byte_in[5:0]};
  assign bl_dec    = bytes_left - 3'd1;

  always_comb begin
    res = '0;
    if (end_of_stream) begin
      res = '0;
    end else if (bytes_left == '0) begin
      if (ones == 3'd0) begin
        res.emit       = 1'b1;
        res.code_point = {24'd0, byte_in};
      end else if (ones == 3'd1) begin
        res.emit       = 1'b1;
        res.code_point = {25'd0, byte_in[6:0]};
      end else begin
        res.acc_next        = {24'd0, byte_in & lead_mask};
        res.bytes_left_next = ones - 3'd1;
        res.seq_len_next    = ones;
      end
    end else if (bl_dec != '0) begin
      res.acc_next        = acc_shift;
      res.bytes_left_next = bl_dec;
      res.seq_len_next    = seq_len;
    end else begin
      res.emit       = 1'b1;
      res.code_point = acc_shift;
      res.overlength = acc_shift[u8d_pkg::CP_W-1] ||
                       (acc_shift < u8d_pkg::min_for_length(seq_len));
    end
  end

endmodule

[sv/utf8_to_code_point_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder
// Byte-serial UTF-8 decoder for sequences of up to six bytes.
// ----------------------------------------------------------------------------
// An accepted byte passes through the input register and then the result
// register before a valid result appears.
// Throughput is one byte per cycle while the output is not stalled.
// Synchronous active-high reset clears the decode state and both valid flags.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module utf8_to_code_point_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] code_point
  output logic        m_axis_tuser    // [0] overlength
);

  logic                       in_valid;
  logic [u8d_pkg::BYTE_W-1:0] in_byte;
  logic                       in_last;

  logic [u8d_pkg::CP_W-1:0]   accumulator;
  logic [u8d_pkg::CNT_W-1:0]  bytes_left;
  logic [u8d_pkg::CNT_W-1:0]  sequence_length;

  u8d_pkg::step_res_t res;
  logic out_free;
  logic fire;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_valid && (out_free || !res.emit);
  assign s_axis_tready = !in_valid || fire;

  u8d_step u_step (
    .byte_in       (in_byte),
    .end_of_stream (in_last),
    .acc           (accumulator),
    .bytes_left    (bytes_left),
    .seq_len       (sequence_length),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator     <= '0;
      bytes_left      <= '0;
      sequence_length <= '0;
    end else if (fire) begin
      accumulator     <= res.acc_next;
      bytes_left      <= res.bytes_left_next;
      sequence_length <= res.seq_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= fire && res.emit;
    end
    if (fire && res.emit) begin
      m_axis_tdata <= res.code_point;
      m_axis_tuser <= res.overlength;
    end
  end

  `ASSERT_PROP(a_bytes_left_range, clk, rst, bytes_left <= 3'd5)
  `ASSERT_PROP(a_len_covers_left, clk, rst, (bytes_left != '0) |-> (sequence_length > bytes_left))
  `ASSERT_PROP(a_end_clears, clk, rst, (fire && in_last) |=> (bytes_left == '0))
  `ASSERT_NEVER(a_no_overwrite, clk, rst, m_axis_tvalid && !m_axis_tready && fire && res.emit)

endmodule
